// ===== src/ccp_pkg.sv =====
// Shared constants, field layout and codes of the circle canvas painter.
package ccp_pkg;

  // Default canvas side; the top level takes it as its parameter default.
  localparam int CCP_MAX_SIDE = 256;

  // Field widths.
  localparam int CMD_W    = 2;
  localparam int COORD_W  = 24;
  localparam int RAD_W    = 23;
  localparam int PAINT_W  = 8;
  localparam int POS_W    = 8;
  localparam int CHAR_W   = 7;
  localparam int STAT_W   = 2;
  localparam int CFG_W    = 9;
  localparam int CFG_IDX_W = 2;

  // Bit offsets of the input fields within s_tdata.
  localparam int OFS_CX    = 0;
  localparam int OFS_CY    = OFS_CX + COORD_W;
  localparam int OFS_RAD   = OFS_CY + COORD_W;
  localparam int OFS_FILL  = OFS_RAD + RAD_W;
  localparam int OFS_PAINT = OFS_FILL + 1;
  localparam int OFS_COL   = OFS_PAINT + PAINT_W;
  localparam int OFS_ROW   = OFS_COL + POS_W;
  localparam int IN_DATA_W = OFS_ROW + POS_W;
  localparam int OUT_DATA_W = 8;

  // Command codes carried on s_tuser.
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DRAW  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

  // Status codes carried on m_tuser.
  localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
  localparam logic [STAT_W-1:0] ST_REJECT  = 2'd1;
  localparam logic [STAT_W-1:0] ST_OUTSIDE = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BG     = 2'd2;

  // Printable character range and register reset values.
  localparam logic [PAINT_W-1:0] CHAR_LO  = 8'd32;
  localparam logic [PAINT_W-1:0] CHAR_HI  = 8'd126;
  localparam logic [CHAR_W-1:0]  BG_RESET = 7'd32;
  localparam logic [CFG_W-1:0]   SIDE_RESET = 9'd1;

endpackage

// ===== src/circle_canvas_painter_core.sv =====
// Circle canvas painter: character canvas with clear, circle draw and pixel read.
// Clear: one canvas write per cycle. Draw: one shared squarer handles one operand
// per cycle (two radius squares, one row offset square per row, one column offset
// square per pixel). Rejected draws, reads outside the canvas and unknown commands
// go straight from idle to the result state.
// Synchronous reset returns to idle, empties the output register and restores the
// registers; the canvas memory is not cleared and holds garbage until written.
module circle_canvas_painter_core
  import ccp_pkg::*;
#(
  parameter int MAX_SIDE = CCP_MAX_SIDE
) (
  input  logic                  clk,
  input  logic                  rst,
  // Input stream.
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // s_tdata, from bit 0: centre_x, centre_y, circle_radius, filled, paint_char,
  // read_col, read_row.
  input  logic [IN_DATA_W-1:0]  s_tdata,
  // s_tuser: command.
  input  logic [CMD_W-1:0]      s_tuser,
  // Result stream.
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // m_tdata, from bit 0: pixel_char, then zero padding.
  output logic [OUT_DATA_W-1:0] m_tdata,
  // m_tuser: status.
  output logic [STAT_W-1:0]     m_tuser,
  // Configuration write channel.
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]      cfg_data
);

  localparam int SIDE_W = $clog2(MAX_SIDE);
  localparam int CNT_W  = $clog2(MAX_SIDE + 1);
  localparam int EXT_W  = (CNT_W > CFG_W) ? CNT_W : CFG_W;
  localparam int ADDR_W = 2 * SIDE_W;
  localparam int DEPTH  = 1 << ADDR_W;
  localparam int OP_W   = ((SIDE_W + 9) > (COORD_W + 1)) ? SIDE_W + 9 : COORD_W + 1;
  localparam int PROD_W = 2 * OP_W;

  typedef enum logic [3:0] {
    S_IDLE, S_CLEAR, S_SETUP_R, S_SETUP_IN, S_ROW, S_COL, S_DRAIN, S_READ, S_DONE
  } state_t;

  typedef enum logic [1:0] {K_RAD, K_INNER, K_ROW, K_COL} kind_t;

  state_t state;

  // Configuration registers.
  logic [CFG_W-1:0]  canvas_width;
  logic [CFG_W-1:0]  canvas_height;
  logic [CHAR_W-1:0] background_char;

  // Latched draw parameters.
  logic signed [COORD_W-1:0] draw_cx;
  logic signed [COORD_W-1:0] draw_cy;
  logic [RAD_W-1:0]          draw_r;
  logic                      draw_filled;
  logic [CHAR_W-1:0]         draw_ch;
  logic                      inner_neg;

  // Sweep counters.
  logic [SIDE_W-1:0] col;
  logic [SIDE_W-1:0] row;

  // Result held until the output register is free.
  logic [CHAR_W-1:0] res_pixel;
  logic [STAT_W-1:0] res_status;

  // Canvas memory.
  logic [CHAR_W-1:0] canvas_store [DEPTH];
  logic [CHAR_W-1:0] rd_data;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [CHAR_W-1:0] wr_data;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;

  // Squarer pipeline.
  logic                    iss_valid;
  kind_t                   iss_kind;
  logic signed [OP_W-1:0]  iss_op;
  logic                    p1_valid;
  kind_t                   p1_kind;
  logic signed [OP_W-1:0]  p1_op;
  logic [ADDR_W-1:0]       p1_addr;
  logic signed [PROD_W-1:0] sq;
  logic                    p2_valid;
  kind_t                   p2_kind;
  logic [PROD_W-1:0]       p2_prod;
  logic [ADDR_W-1:0]       p2_addr;
  logic                    p3_valid;
  logic [PROD_W-1:0]       p3_d2;
  logic [ADDR_W-1:0]       p3_addr;
  logic [PROD_W-1:0]       r2;
  logic [PROD_W-1:0]       inner2;
  logic [PROD_W-1:0]       dy2;
  logic                    paint;

  // Decoded input fields.
  logic signed [COORD_W-1:0] in_cx;
  logic signed [COORD_W-1:0] in_cy;
  logic [RAD_W-1:0]          in_r;
  logic                      in_fill;
  logic [PAINT_W-1:0]        in_paint;
  logic [POS_W-1:0]          in_col;
  logic [POS_W-1:0]          in_row;
  logic                      accept;
  logic                      draw_bad;
  logic                      read_out;

  // Canvas extent in use and sweep end flags.
  logic [EXT_W-1:0] ext_w;
  logic [EXT_W-1:0] ext_h;
  logic [CNT_W-1:0] w_use;
  logic [CNT_W-1:0] h_use;
  logic             empty;
  logic             col_last;
  logic             row_last;

  assign in_cx    = s_tdata[OFS_CX +: COORD_W];
  assign in_cy    = s_tdata[OFS_CY +: COORD_W];
  assign in_r     = s_tdata[OFS_RAD +: RAD_W];
  assign in_fill  = s_tdata[OFS_FILL];
  assign in_paint = s_tdata[OFS_PAINT +: PAINT_W];
  assign in_col   = s_tdata[OFS_COL +: POS_W];
  assign in_row   = s_tdata[OFS_ROW +: POS_W];

  assign s_tready  = (state == S_IDLE);
  assign accept    = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;

  // Sizes above the canvas saturate.
  assign ext_w = EXT_W'(canvas_width);
  assign ext_h = EXT_W'(canvas_height);
  assign w_use = (ext_w > EXT_W'(MAX_SIDE)) ? CNT_W'(MAX_SIDE) : CNT_W'(ext_w);
  assign h_use = (ext_h > EXT_W'(MAX_SIDE)) ? CNT_W'(MAX_SIDE) : CNT_W'(ext_h);
  assign empty = (w_use == '0) || (h_use == '0);

  assign col_last = (CNT_W'(col) + CNT_W'(1)) == w_use;
  assign row_last = (CNT_W'(row) + CNT_W'(1)) == h_use;

  assign draw_bad = (in_r == '0) || (in_paint < CHAR_LO) || (in_paint > CHAR_HI);
  assign read_out = (in_col >= w_use) || (in_row >= h_use);

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      canvas_width    <= SIDE_RESET;
      canvas_height   <= SIDE_RESET;
      background_char <= BG_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_WIDTH:  canvas_width    <= cfg_data;
        REG_HEIGHT: canvas_height   <= cfg_data;
        REG_BG:     background_char <= cfg_data[CHAR_W-1:0];
        default: ;
      endcase
    end
  end

  // Operand issued to the squarer by the sequencer.
  always_comb begin
    iss_valid = 1'b0;
    iss_kind  = K_COL;
    iss_op    = OP_W'({col, 8'h00}) - OP_W'(draw_cx);
    case (state)
      S_SETUP_R: begin
        iss_valid = 1'b1;
        iss_kind  = K_RAD;
        iss_op    = OP_W'(draw_r);
      end
      S_SETUP_IN: begin
        iss_valid = 1'b1;
        iss_kind  = K_INNER;
        iss_op    = OP_W'(draw_r) - OP_W'(256);
      end
      S_ROW: begin
        iss_valid = 1'b1;
        iss_kind  = K_ROW;
        iss_op    = OP_W'({row, 8'h00}) - OP_W'(draw_cy);
      end
      S_COL: begin
        iss_valid = 1'b1;
      end
      default: ;
    endcase
  end

  assign sq = p1_op * p1_op;

  // Squarer pipeline: operand, square, sum of squares.
  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
      p2_valid <= 1'b0;
      p3_valid <= 1'b0;
    end else begin
      p1_valid <= iss_valid;
      p2_valid <= p1_valid;
      p3_valid <= p2_valid && (p2_kind == K_COL);
    end
    p1_kind <= iss_kind;
    p1_op   <= iss_op;
    p1_addr <= {row, col};
    p2_kind <= p1_kind;
    p2_prod <= $unsigned(sq);
    p2_addr <= p1_addr;
    p3_d2   <= p2_prod + dy2;
    p3_addr <= p2_addr;
    if (p2_valid) begin
      case (p2_kind)
        K_RAD:   r2     <= p2_prod;
        K_INNER: inner2 <= p2_prod;
        K_ROW:   dy2    <= p2_prod;
        default: ;
      endcase
    end
  end

  // Ring or disc test on the sum of squares.
  assign paint = (p3_d2 <= r2) && (draw_filled || inner_neg || (p3_d2 > inner2));

  // Single write port shared by the clear sweep and the draw pipeline.
  always_comb begin
    if (state == S_CLEAR) begin
      wr_en   = 1'b1;
      wr_addr = {row, col};
      wr_data = background_char;
    end else begin
      wr_en   = p3_valid && paint;
      wr_addr = p3_addr;
      wr_data = draw_ch;
    end
  end

  assign rd_en   = accept && (s_tuser == CMD_READ) && !read_out;
  assign rd_addr = {SIDE_W'(in_row), SIDE_W'(in_col)};

  always_ff @(posedge clk) begin
    if (wr_en) begin
      canvas_store[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= canvas_store[rd_addr];
    end
  end

  // Sequencer and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            col        <= '0;
            row        <= '0;
            res_pixel  <= '0;
            res_status <= ST_OK;
            case (s_tuser)
              CMD_CLEAR: begin
                state <= empty ? S_DONE : S_CLEAR;
              end
              CMD_DRAW: begin
                draw_cx     <= in_cx;
                draw_cy     <= in_cy;
                draw_r      <= in_r;
                draw_filled <= in_fill;
                draw_ch     <= in_paint[CHAR_W-1:0];
                inner_neg   <= in_r < RAD_W'(256);
                if (draw_bad) begin
                  res_status <= ST_REJECT;
                  state      <= S_DONE;
                end else begin
                  state <= S_SETUP_R;
                end
              end
              CMD_READ: begin
                if (read_out) begin
                  res_status <= ST_OUTSIDE;
                  state      <= S_DONE;
                end else begin
                  state <= S_READ;
                end
              end
              default: begin
                state <= S_DONE;
              end
            endcase
          end
        end
        S_CLEAR: begin
          if (col_last) begin
            col <= '0;
            if (row_last) begin
              state <= S_DONE;
            end else begin
              row <= row + SIDE_W'(1);
            end
          end else begin
            col <= col + SIDE_W'(1);
          end
        end
        S_SETUP_R: begin
          state <= S_SETUP_IN;
        end
        S_SETUP_IN: begin
          state <= empty ? S_DRAIN : S_ROW;
        end
        S_ROW: begin
          col   <= '0;
          state <= S_COL;
        end
        S_COL: begin
          if (col_last) begin
            if (row_last) begin
              state <= S_DRAIN;
            end else begin
              row   <= row + SIDE_W'(1);
              state <= S_ROW;
            end
          end else begin
            col <= col + SIDE_W'(1);
          end
        end
        S_DRAIN: begin
          if (!p1_valid && !p2_valid && !p3_valid) begin
            state <= S_DONE;
          end
        end
        S_READ: begin
          res_pixel <= rd_data;
          state     <= S_DONE;
        end
        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= OUT_DATA_W'(res_pixel);
            m_tuser  <= res_status;
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== src/ccp_checker.sv =====
// Port-level checks of the circle canvas painter and their binding to the top level.
module ccp_checker
  import ccp_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  s_tvalid,
  input logic                  s_tready,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [OUT_DATA_W-1:0] m_tdata,
  input logic [STAT_W-1:0]     m_tuser
);

  // A stalled result holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  // After reset the block is idle and has no result pending.
  a_reset_idle: assert property (@(posedge clk)
    rst |=> s_tready && !m_tvalid)
    else $error("block not idle after reset");

  // Items are worked on one at a time.
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second item taken while busy");

  // Only a successful transaction carries a character.
  a_zero_pixel: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser != ST_OK) |-> (m_tdata == '0))
    else $error("character returned with a failing status");

endmodule

bind circle_canvas_painter_core ccp_checker u_ccp_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
